>>> rtl/spectrum_band_peak_hold_meter_unit_macros.svh
// Assertion macros for the spectrum band peak-hold meter.
`ifndef SPECTRUM_BAND_PEAK_HOLD_METER_UNIT_MACROS_SVH
`define SPECTRUM_BAND_PEAK_HOLD_METER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SBPM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SBPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SBPM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SBPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/sbpm_pkg.sv
// Shared constants, types and functions of the spectrum band peak-hold meter.
package sbpm_pkg;

	localparam int BIN_COUNT   = 512;
	localparam int BAND_COUNT  = 10;
	localparam int LEVEL_COUNT = 14;
	localparam int MAG_W       = 31;
	localparam int BIN_W       = 9;
	localparam int BAND_W      = 4;
	localparam int LEVEL_W     = 4;
	localparam int FIFTHS_W    = 7;
	localparam int HOLD_W      = 8;
	localparam int DECAY_W     = 7;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_DEPTH   = 4;

	localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RST  = HOLD_W'(3);
	localparam logic [DECAY_W-1:0] DECAY_FIFTHS_RST = DECAY_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_FRAMES  = 1'b0,
		CFG_DECAY_FIFTHS = 1'b1
	} cfg_index_t;

	localparam logic [MAG_W-1:0] LEVEL_FLOOR [LEVEL_COUNT] = '{
		MAG_W'(365 * 1024),   MAG_W'(518 * 1024),   MAG_W'(704 * 1024),
		MAG_W'(1024 * 1024),  MAG_W'(1472 * 1024),  MAG_W'(2048 * 1024),
		MAG_W'(2944 * 1024),  MAG_W'(4096 * 1024),  MAG_W'(5824 * 1024),
		MAG_W'(8192 * 1024),  MAG_W'(11584 * 1024), MAG_W'(16000 * 1024),
		MAG_W'(22400 * 1024), MAG_W'(30720 * 1024)
	};

	// A band that closes, handed from the band tracker to the peak-hold stage.
	typedef struct packed {
		logic              valid;
		logic [BAND_W-1:0] band;
		logic [MAG_W-1:0]  band_max;
	} close_t;

	typedef struct packed {
		logic [BAND_W-1:0]  band;
		logic [LEVEL_W-1:0] display_level;
		logic [LEVEL_W-1:0] instant_level;
		logic               last_band;
	} result_t;

	function automatic logic [BIN_W-1:0] band_last_bin(input logic [BAND_W-1:0] b);
		logic [BIN_W-1:0] r;
		unique case (b)
			BAND_W'(0): r = BIN_W'(1);
			BAND_W'(1): r = BIN_W'(2);
			BAND_W'(2): r = BIN_W'(4);
			BAND_W'(3): r = BIN_W'(8);
			BAND_W'(4): r = BIN_W'(18);
			BAND_W'(5): r = BIN_W'(35);
			BAND_W'(6): r = BIN_W'(57);
			BAND_W'(7): r = BIN_W'(149);
			BAND_W'(8): r = BIN_W'(298);
			default:    r = BIN_W'(BIN_COUNT - 1);
		endcase
		return r;
	endfunction

	// The thresholds rise, so the level is the count of thresholds met.
	function automatic logic [LEVEL_W-1:0] quantize(input logic [MAG_W-1:0] m);
		logic [LEVEL_W-1:0] lvl;
		lvl = '0;
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			if (m >= LEVEL_FLOOR[i]) begin
				lvl = LEVEL_W'(i + 1);
			end
		end
		return lvl;
	endfunction

endpackage

>>> rtl/sbpm_band_tracker.sv
// Input register, bin counter, band index and running band maximum.
module sbpm_band_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [sbpm_pkg::MAG_W-1:0]   in_magnitude,
	input  logic                         in_frame_end,
	output logic                         valid_s1,
	output sbpm_pkg::close_t             close_s2
);

	logic [sbpm_pkg::MAG_W-1:0]  mag_s1;
	logic                        fend_s1;
	logic [sbpm_pkg::BIN_W-1:0]  bin_q;
	logic [sbpm_pkg::BAND_W-1:0] band_q;
	logic [sbpm_pkg::MAG_W-1:0]  max_q;
	logic                        close_valid_s2;
	logic [sbpm_pkg::BAND_W-1:0] close_band_s2;
	logic [sbpm_pkg::MAG_W-1:0]  close_max_s2;

	logic [sbpm_pkg::BAND_W-1:0] band_cur;
	logic [sbpm_pkg::BAND_W-1:0] band_inc;
	logic [sbpm_pkg::MAG_W-1:0]  max_new;
	logic                        hit;

	always_comb begin
		band_cur = (band_q >= sbpm_pkg::BAND_W'(sbpm_pkg::BAND_COUNT)) ? '0 : band_q;
		band_inc = (band_cur == sbpm_pkg::BAND_W'(sbpm_pkg::BAND_COUNT - 1)) ? '0
		           : band_cur + sbpm_pkg::BAND_W'(1);
		max_new  = (mag_s1 > max_q) ? mag_s1 : max_q;
		hit      = valid_s1 && (bin_q != '0)
		           && (bin_q == sbpm_pkg::band_last_bin(band_cur));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			close_valid_s2 <= 1'b0;
			bin_q          <= '0;
			band_q         <= '0;
			max_q          <= '0;
		end else begin
			valid_s1       <= in_valid;
			close_valid_s2 <= hit;
			if (valid_s1) begin
				if (fend_s1) begin
					// End of frame: any unfinished band is dropped.
					bin_q  <= '0;
					band_q <= '0;
					max_q  <= '0;
				end else begin
					bin_q  <= (bin_q == sbpm_pkg::BIN_W'(sbpm_pkg::BIN_COUNT - 1)) ? '0
					          : bin_q + sbpm_pkg::BIN_W'(1);
					band_q <= hit ? band_inc : band_cur;
					if (hit) begin
						max_q <= '0;
					end else if (bin_q != '0) begin
						max_q <= max_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			mag_s1  <= in_magnitude;
			fend_s1 <= in_frame_end;
		end
		if (hit) begin
			close_band_s2 <= band_cur;
			close_max_s2  <= max_new;
		end
	end

	assign close_s2 = '{valid: close_valid_s2, band: close_band_s2, band_max: close_max_s2};

endmodule

>>> rtl/sbpm_peak_hold.sv
// Level quantizer, configuration registers and per-band peak-hold stores.
module sbpm_peak_hold (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbpm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  sbpm_pkg::close_t                  close_s2,
	output logic                              push,
	output sbpm_pkg::result_t                 result
);

	logic [sbpm_pkg::HOLD_W-1:0]   hold_frames_q;
	logic [sbpm_pkg::DECAY_W-1:0]  decay_fifths_q;
	logic [sbpm_pkg::FIFTHS_W-1:0] peak_q [sbpm_pkg::BAND_COUNT];
	logic [sbpm_pkg::HOLD_W-1:0]   hold_q [sbpm_pkg::BAND_COUNT];

	logic [sbpm_pkg::LEVEL_W-1:0]  lvl;
	logic [sbpm_pkg::FIFTHS_W-1:0] lvl5;
	logic [sbpm_pkg::FIFTHS_W-1:0] peak_cur;
	logic [sbpm_pkg::HOLD_W-1:0]   hold_cur;
	logic [sbpm_pkg::FIFTHS_W-1:0] peak_nxt;
	logic [sbpm_pkg::HOLD_W-1:0]   hold_nxt;
	logic [13:0]                   div_prod;

	always_comb begin
		lvl      = sbpm_pkg::quantize(close_s2.band_max);
		lvl5     = {3'b000, lvl} * sbpm_pkg::FIFTHS_W'(5);
		peak_cur = peak_q[close_s2.band];
		hold_cur = hold_q[close_s2.band];
		peak_nxt = peak_cur;
		hold_nxt = hold_cur;
		priority if (lvl5 > peak_cur) begin
			peak_nxt = lvl5;
			hold_nxt = hold_frames_q;
		end else if (hold_cur != '0) begin
			hold_nxt = hold_cur - sbpm_pkg::HOLD_W'(1);
		end else begin
			peak_nxt = (peak_cur > decay_fifths_q) ? peak_cur - decay_fifths_q : '0;
		end
		// Divide by 5 as a multiply by 205/1024; exact for all reachable peaks.
		div_prod = 14'(peak_nxt) * 14'd205;
	end

	assign push   = close_s2.valid;
	assign result = '{
		band:          close_s2.band,
		display_level: div_prod[13:10],
		instant_level: lvl,
		last_band:     close_s2.band == sbpm_pkg::BAND_W'(sbpm_pkg::BAND_COUNT - 1)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_frames_q  <= sbpm_pkg::HOLD_FRAMES_RST;
			decay_fifths_q <= sbpm_pkg::DECAY_FIFTHS_RST;
			for (int i = 0; i < sbpm_pkg::BAND_COUNT; i++) begin
				peak_q[i] <= '0;
				hold_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (sbpm_pkg::cfg_index_t'(cfg_index))
					sbpm_pkg::CFG_HOLD_FRAMES: begin
						hold_frames_q <= cfg_wdata[sbpm_pkg::HOLD_W-1:0];
					end
					sbpm_pkg::CFG_DECAY_FIFTHS: begin
						decay_fifths_q <= cfg_wdata[sbpm_pkg::DECAY_W-1:0];
					end
				endcase
			end
			if (close_s2.valid) begin
				peak_q[close_s2.band] <= peak_nxt;
				hold_q[close_s2.band] <= hold_nxt;
			end
		end
	end

endmodule

>>> rtl/sbpm_out_fifo.sv
// Small result queue that decouples the pipeline from the output channel.
module sbpm_out_fifo #(
	parameter int DEPTH = sbpm_pkg::OUT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  sbpm_pkg::result_t            push_data,
	input  logic                         pop_ready,
	output logic                         out_valid,
	output sbpm_pkg::result_t            out_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbpm_pkg::result_t  entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/spectrum_band_peak_hold_meter_unit.sv
// Spectrum band peak-hold meter: top level with ports, flow control and checks.
//
// Input stream: one magnitude bin per transaction, lowest frequency first.
// s_tdata[30:0] is the magnitude, s_tlast marks the last bin of a frame.
// Bin 0 of each frame is ignored; the rest fall into ten bands of non-decreasing width.
// Output stream: one transaction each time a band closes. m_tlast is set
// for band 9, which ends the results of a frame.
// A bin that closes a band passes the input register, then the band register;
// its result is then written into the result queue and shows on m_tvalid.
// Throughput: one bin per cycle, sustained while the receiver keeps up.
// s_tready is high while the items in flight plus the queued results are
// fewer than OUT_DEPTH, so a stalled receiver fills the queue and then
// holds off the sender; nothing is lost.
// Configuration: cfg_we with cfg_index 0 writes hold_frames, index 1 writes
// decay_fifths; write only while the block is idle.
// Reset clears the bin counter, the band state, all peak and hold stores,
// empties the queue and loads hold_frames = 3, decay_fifths = 1.
`include "spectrum_band_peak_hold_meter_unit_macros.svh"
module spectrum_band_peak_hold_meter_unit #(
	parameter int OUT_DEPTH = sbpm_pkg::OUT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // [30:0] magnitude, [31] zero
	input  logic                              s_tlast,   // frame_end
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // [3:0] band, [7:4] display_level,
	                                                     // [11:8] instant_level, [15:12] zero
	output logic                              m_tlast,   // last_band
	input  logic                              cfg_we,
	input  logic [sbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbpm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int SUM_W = $clog2(OUT_DEPTH + 3);

	logic                 in_accept;
	logic                 valid_s1;
	sbpm_pkg::close_t     close_s2;
	logic                 push;
	sbpm_pkg::result_t    push_data;
	sbpm_pkg::result_t    out_data;
	logic [CNT_W-1:0]     fifo_count;
	logic [SUM_W-1:0]     inflight;
	logic                 band_is_last;

	// Every item in the pipeline may still produce a result; reserve queue room for it.
	assign inflight  = SUM_W'(fifo_count) + SUM_W'(valid_s1) + SUM_W'(close_s2.valid);
	assign s_tready  = inflight < SUM_W'(OUT_DEPTH);
	assign in_accept = s_tvalid && s_tready;

	sbpm_band_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_accept),
		.in_magnitude (s_tdata[sbpm_pkg::MAG_W-1:0]),
		.in_frame_end (s_tlast),
		.valid_s1     (valid_s1),
		.close_s2     (close_s2)
	);

	sbpm_peak_hold u_peak (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.close_s2  (close_s2),
		.push      (push),
		.result    (push_data)
	);

	sbpm_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_data),
		.count     (fifo_count)
	);

	assign m_tdata = {4'b0000, out_data.instant_level, out_data.display_level, out_data.band};
	assign m_tlast = out_data.last_band;

	assign band_is_last = out_data.band == sbpm_pkg::BAND_W'(sbpm_pkg::BAND_COUNT - 1);

	`SBPM_ASSERT_IMPLY(a_no_overflow, 1'b1, inflight <= SUM_W'(OUT_DEPTH), "result queue overbooked")
	`SBPM_ASSERT_NEXT(a_close_lands, close_s2.valid, fifo_count != '0, "closed band not queued")
	`SBPM_ASSERT_IMPLY(a_last_band, m_tvalid, m_tlast == band_is_last, "last_band flag mismatch")

endmodule
